// ----- rtl/nch_pkg.sv -----
`default_nettype none

package nch_pkg;

   localparam int NOTES_DEFAULT      = 64;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int BINS       = 20;
   localparam int LAST_BIN   = 19;
   localparam int CENTER_BIN = 10;
   localparam int BIN_W      = 5;
   localparam int CENT_BIAS  = 50;
   localparam int CENT_SPAN  = 100;

   localparam int CMD_W   = 2;
   localparam int NOTE_W  = 7;
   localparam int CENT_W  = 7;
   localparam int THR_W   = 6;
   localparam int SUM_W   = 21;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_COUNT = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

   // Division by five through the reciprocal 205/1024, exact for 0..127.
   function automatic logic [BIN_W-1:0] div5(input logic [6:0] x);
      logic [14:0] prod;
      prod = 15'(x) * 15'd205;
      return prod[14:10];
   endfunction

   // Cent offset to bin number, clamped to the first and the last bin.
   function automatic logic [BIN_W-1:0] cent_to_bin(input logic signed [CENT_W-1:0] cent);
      logic signed [CENT_W:0] v;
      v = {cent[CENT_W-1], cent} + (CENT_W + 1)'(CENT_BIAS);
      if (v[CENT_W]) begin
         return '0;
      end else if (v >= (CENT_W + 1)'(CENT_SPAN)) begin
         return BIN_W'(LAST_BIN);
      end else begin
         return div5(v[CENT_W-1:0]);
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/nch_if.sv -----
`default_nettype none

interface nch_req_if import nch_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [NOTE_W-1:0] note_index;
   logic signed [CENT_W-1:0] cent_offset;

   modport source (output valid, command, note_index, cent_offset, input ready);
   modport sink   (input valid, command, note_index, cent_offset, output ready);
endinterface

interface nch_rsp_if import nch_pkg::*;;
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] flat_sum;
   logic [SUM_W-1:0] in_tune_sum;
   logic [SUM_W-1:0] sharp_sum;

   modport source (output valid, flat_sum, in_tune_sum, sharp_sum, input ready);
   modport sink   (input valid, flat_sum, in_tune_sum, sharp_sum, output ready);
endinterface

interface nch_csr_if import nch_pkg::*;;
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/nch_bin_ram.sv -----
`default_nettype none

module nch_bin_ram import nch_pkg::*; #(
   parameter int DEPTH  = NOTES_DEFAULT * BINS,
   parameter int WIDTH  = COUNT_BITS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire mem_cmd_type       mem_cmd,
   input  wire logic [ADDR_W-1:0] mem_addr,
   input  wire logic [WIDTH-1:0]  mem_wdata,
   output logic      [WIDTH-1:0]  mem_rdata
);

   logic [WIDTH-1:0] bin_mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         bin_mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.rd_en) begin
         rdata_ff <= bin_mem_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/nch_ctrl.sv -----
`default_nettype none

module nch_ctrl import nch_pkg::*; #(
   parameter  int NOTES      = NOTES_DEFAULT,
   parameter  int COUNT_BITS = COUNT_BITS_DEFAULT,
   localparam int DEPTH      = NOTES * BINS,
   localparam int ADDR_W     = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   nch_req_if.sink                    req,
   nch_rsp_if.source                  rsp,
   input  wire logic [THR_W-1:0]      threshold,
   output mem_cmd_type                mem_cmd,
   output logic      [ADDR_W-1:0]     mem_addr,
   output logic      [COUNT_BITS-1:0] mem_wdata,
   input  wire logic [COUNT_BITS-1:0] mem_rdata
);

   localparam int ACC_W = ((SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS) + 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_COUNT = 6'b000100,
      S_SUM   = 6'b001000,
      S_RESP  = 6'b010000,
      S_SPARE = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;
   logic [BIN_W-1:0]  lo_ff, lo_in;
   logic [BIN_W-1:0]  hi_ff, hi_in;
   logic [SUM_W-1:0]  flat_ff, flat_in;
   logic [SUM_W-1:0]  tune_ff, tune_in;
   logic [SUM_W-1:0]  sharp_ff, sharp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_flat_ff, rsp_tune_ff, rsp_sharp_ff;
   logic              rsp_load;

   cmd_type           cmd;
   logic              req_fire;
   logic              note_ok;
   logic [5:0]        note_u;
   logic [ADDR_W-1:0] row_base;
   logic [BIN_W-1:0]  bin;
   logic [BIN_W-1:0]  half;
   logic [BIN_W-1:0]  lo_calc, hi_calc;
   logic [SUM_W-1:0]  acc_sel;
   logic [ACC_W-1:0]  acc_wide;
   logic [SUM_W-1:0]  acc_next;
   logic [COUNT_BITS-1:0] count_inc;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign cmd       = cmd_type'(req.command);

   assign note_u   = req.note_index[5:0];
   assign note_ok  = !req.note_index[NOTE_W-1] && ({3'b000, note_u} < 9'(NOTES));
   // Row base is note * 20, built from two shifts.
   assign row_base = (ADDR_W'(note_u) << 4) + (ADDR_W'(note_u) << 2);
   assign bin      = cent_to_bin(req.cent_offset);

   assign half    = div5({1'b0, threshold});
   assign lo_calc = (half >= BIN_W'(CENTER_BIN)) ? '0 : BIN_W'(CENTER_BIN) - half;
   assign hi_calc = (half >= BIN_W'(CENTER_BIN)) ? BIN_W'(BINS) : BIN_W'(CENTER_BIN) + half;

   // One saturating adder serves the three sums; the bin index picks the sum.
   always_comb begin
      if (idx_ff < lo_ff) begin
         acc_sel = flat_ff;
      end else if (idx_ff < hi_ff) begin
         acc_sel = tune_ff;
      end else begin
         acc_sel = sharp_ff;
      end
   end

   assign acc_wide  = ACC_W'(acc_sel) + ACC_W'(mem_rdata);
   assign acc_next  = (acc_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_wide[SUM_W-1:0];
   assign count_inc = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      flat_in      = flat_ff;
      tune_in      = tune_ff;
      sharp_in     = sharp_ff;
      rsp_load     = 1'b0;
      mem_cmd      = '0;
      mem_addr     = addr_ff;
      mem_wdata    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            addr_in       = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_COUNT: begin
                     if (note_ok) begin
                        mem_cmd.rd_en = 1'b1;
                        mem_addr      = row_base + ADDR_W'(bin);
                        addr_in       = row_base + ADDR_W'(bin);
                        state_in      = S_COUNT;
                     end
                  end
                  CMD_QUERY: begin
                     flat_in  = '0;
                     tune_in  = '0;
                     sharp_in = '0;
                     idx_in   = '0;
                     lo_in    = lo_calc;
                     hi_in    = hi_calc;
                     if (note_ok) begin
                        mem_cmd.rd_en = 1'b1;
                        mem_addr      = row_base;
                        addr_in       = row_base + ADDR_W'(1);
                        state_in      = S_SUM;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  CMD_CLEAR: begin
                     addr_in  = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_NONE: begin
                  end
               endcase
            end
         end
         S_COUNT: begin
            mem_cmd.wr_en = 1'b1;
            mem_wdata     = count_inc;
            state_in      = S_IDLE;
         end
         S_SUM: begin
            if (idx_ff < lo_ff) begin
               flat_in = acc_next;
            end else if (idx_ff < hi_ff) begin
               tune_in = acc_next;
            end else begin
               sharp_in = acc_next;
            end
            idx_in = idx_ff + BIN_W'(1);
            if (idx_ff == BIN_W'(LAST_BIN)) begin
               state_in = S_RESP;
            end else begin
               mem_cmd.rd_en = 1'b1;
               addr_in       = addr_ff + ADDR_W'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      flat_ff  <= flat_in;
      tune_ff  <= tune_in;
      sharp_ff <= sharp_in;
      if (rsp_load) begin
         rsp_flat_ff  <= flat_ff;
         rsp_tune_ff  <= tune_ff;
         rsp_sharp_ff <= sharp_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.flat_sum    = rsp_flat_ff;
   assign rsp.in_tune_sum = rsp_tune_ff;
   assign rsp.sharp_sum   = rsp_sharp_ff;

   // A counted beat writes back to the address that it read in the cycle before.
   a_count_writeback: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd == CMD_COUNT && note_ok
      |=> state_ff == S_COUNT && mem_cmd.wr_en && mem_addr == $past(mem_addr))
      else $error("count write-back lost its address");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == S_CLEAR) |-> $past(addr_ff) == ADDR_W'(DEPTH - 1))
      else $error("clearing pass ended early");

   a_sum_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SUM |-> idx_ff <= BIN_W'(LAST_BIN) && lo_ff <= hi_ff)
      else $error("query walk out of the row");

   a_resp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_flat_ff)
                                     && $stable(rsp_sharp_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- rtl/note_cent_histogram_core.sv -----
`default_nettype none

// Per-note cent histogram: NOTES rows of 20 saturating bins held in one
// single-port memory with one entry per bin. A count beat reads its bin,
// then writes it back. A query beat walks its row one bin per cycle, and
// its result is then loaded into the output register once any earlier
// result in that register has drained. After reset and after a clear beat
// the memory is zeroed one entry per cycle, during which no request is
// taken; threshold writes are taken at any time.

module note_cent_histogram_core import nch_pkg::*; #(
   parameter int NOTES      = NOTES_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   nch_req_if.sink   req_bus,
   nch_rsp_if.source rsp_bus,
   nch_csr_if.sink   csr_bus
);

   localparam int DEPTH  = NOTES * BINS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [THR_W-1:0]      thr_ff;
   mem_cmd_type           mem_cmd;
   logic [ADDR_W-1:0]     mem_addr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] mem_rdata;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_bus.valid) begin
         thr_ff <= csr_bus.wdata;
      end
   end

   nch_ctrl #(
      .NOTES      (NOTES),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .threshold (thr_ff),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   nch_bin_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (COUNT_BITS),
      .ADDR_W (ADDR_W)
   ) u_bin_ram (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire
